>>> sv/sensor_slot_aggregator_unit_assert.svh
// Assertion macros shared by the checker of the sensor slot aggregator.
// No dependencies; clk and rst_n must be visible where the macros are used.
`ifndef SENSOR_SLOT_AGGREGATOR_UNIT_ASSERT_SVH
`define SENSOR_SLOT_AGGREGATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define SSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/ssa_pkg.sv
// Shared constants and types of the sensor slot aggregator.
// No dependencies; used by ssa_cell and sensor_slot_aggregator_unit.
package ssa_pkg;

  localparam int SLOTS     = 16;
  localparam int ID_W      = 16;
  localparam int VAL_W     = 16;
  localparam int TIME_W    = 32;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_AGG_TIMEOUT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_STALE_THR   = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] CFG_RESET_VAL = CFG_W'(60000);

  // broadcast from the controller to every cell
  typedef struct packed {
    logic              scan;
    logic              flush;
    logic [ID_W-1:0]   id;
    logic [VAL_W-1:0]  temp;
    logic [VAL_W-1:0]  humid;
    logic [TIME_W-1:0] time_now;
    logic [CFG_W-1:0]  stale_thr;
  } cell_ctl_t;

  // record a cell presents while it holds the flush token (zero otherwise)
  typedef struct packed {
    logic             valid;
    logic [ID_W-1:0]  id;
    logic [VAL_W-1:0] temp;
    logic [VAL_W-1:0] humid;
    logic             stale;
    logic             last;
  } cell_rec_t;

endpackage

>>> sv/sensor_slot_aggregator_unit.sv
// Top level of the sensor slot aggregator: controller and chain of slot cells.
// Depends on ssa_pkg and ssa_cell.
//
//  channel   | handshake            | payload
//  ----------+----------------------+---------------------------------------------
//  input     | start / busy         | in_kind, in_sensor_id, in_temperature, in_humidity
//  result    | out_valid (strobe)   | out_sensor_id, out_temperature, out_humidity,
//            |                      | out_stale, out_last
//  config    | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A tick is accepted and then goes through the flush check. A reading walks a token down the
// cell chain one slot per cycle until it is stored or falls off the table. A flush walks the
// used slots; records leave one per cycle, each passing through the result register.
// Synchronous active-low reset frees all slots, zeroes time and timer start,
// and sets both settings to 60000 ticks. cfg_ready is always high.
// The receiver cannot stall.
module sensor_slot_aggregator_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_kind,
  input  logic [ssa_pkg::ID_W-1:0]           in_sensor_id,
  input  logic signed [ssa_pkg::VAL_W-1:0]   in_temperature,
  input  logic [ssa_pkg::VAL_W-1:0]          in_humidity,
  output logic                               out_valid,
  output logic [ssa_pkg::ID_W-1:0]           out_sensor_id,
  output logic signed [ssa_pkg::VAL_W-1:0]   out_temperature,
  output logic [ssa_pkg::VAL_W-1:0]          out_humidity,
  output logic                               out_stale,
  output logic                               out_last,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ssa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ssa_pkg::CFG_W-1:0]          cfg_data
);
  import ssa_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_CHECK = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [TIME_W-1:0] time_now_r, time_now_nxt;
  logic [TIME_W-1:0] timer_start_r, timer_start_nxt;
  logic [TIME_W-1:0] elapsed;
  logic [CFG_W-1:0]  timeout_r, stale_thr_r;
  logic [ID_W-1:0]   item_id_r;
  logic [VAL_W-1:0]  item_temp_r, item_humid_r;

  logic              accept, inject, flush_go, any_used, all_done, scan_end;
  cell_ctl_t         ctl;
  cell_rec_t         rec_all;
  cell_rec_t         rec_v [SLOTS];
  logic [SLOTS:0]    tok_w;
  logic [SLOTS-1:0]  hit_v, used_v, done_v;

  logic              out_valid_r, out_stale_r, out_last_r;
  logic [ID_W-1:0]   out_id_r;
  logic [VAL_W-1:0]  out_temp_r, out_humid_r;

  assign cfg_ready = 1'b1;
  assign busy      = (state_r != ST_IDLE);
  assign accept    = start & ~busy;

  // ---- cell chain -----------------------------------------------------------
  assign ctl.scan      = (state_r == ST_SCAN);
  assign ctl.flush     = (state_r == ST_FLUSH);
  assign ctl.id        = item_id_r;
  assign ctl.temp      = item_temp_r;
  assign ctl.humid     = item_humid_r;
  assign ctl.time_now  = time_now_r;
  assign ctl.stale_thr = stale_thr_r;

  assign tok_w[0] = inject;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    logic next_used;
    if (g == SLOTS - 1) begin : g_end
      assign next_used = 1'b0;
    end else begin : g_mid
      assign next_used = used_v[g+1];
    end
    ssa_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl_i       (ctl),
      .tok_i       (tok_w[g]),
      .next_used_i (next_used),
      .tok_o       (tok_w[g+1]),
      .hit_o       (hit_v[g]),
      .used_o      (used_v[g]),
      .done_o      (done_v[g]),
      .rec_o       (rec_v[g])
    );
  end

  // only the token holder drives a nonzero record
  always_comb begin
    rec_all = '0;
    for (int i = 0; i < SLOTS; i++) begin
      rec_all = rec_all | rec_v[i];
    end
  end

  // ---- flush decision -------------------------------------------------------
  assign any_used = |used_v;
  assign all_done = &done_v;
  assign elapsed  = time_now_r - timer_start_r;
  assign flush_go = any_used &
                    (all_done | (elapsed >= {{(TIME_W-CFG_W){1'b0}}, timeout_r}));

  // token enters cell 0 on a reading or on a flush decision
  assign inject   = (accept & ~in_kind) | ((state_r == ST_CHECK) & flush_go);
  // scan ends on a stored reading or when the token falls off a full table
  assign scan_end = (|hit_v) | tok_w[SLOTS];

  // ---- controller -----------------------------------------------------------
  always_comb begin
    state_nxt       = state_r;
    time_now_nxt    = time_now_r;
    timer_start_nxt = timer_start_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_kind) begin
            time_now_nxt = time_now_r + TIME_W'(1);
            state_nxt    = ST_CHECK;
          end else begin
            state_nxt    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = flush_go ? ST_FLUSH : ST_IDLE;
      end
      ST_FLUSH: begin
        if (rec_all.last) begin
          state_nxt       = ST_IDLE;
          timer_start_nxt = time_now_r;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      time_now_r    <= '0;
      timer_start_r <= '0;
      timeout_r     <= CFG_RESET_VAL;
      stale_thr_r   <= CFG_RESET_VAL;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      time_now_r    <= time_now_nxt;
      timer_start_r <= timer_start_nxt;
      out_valid_r   <= rec_all.valid;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_AGG_TIMEOUT: timeout_r   <= cfg_data;
          CFG_STALE_THR:   stale_thr_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // item payload and result register
  always_ff @(posedge clk) begin
    if (accept) begin
      item_id_r    <= in_sensor_id;
      item_temp_r  <= in_temperature;
      item_humid_r <= in_humidity;
    end
    out_id_r    <= rec_all.id;
    out_temp_r  <= rec_all.temp;
    out_humid_r <= rec_all.humid;
    out_stale_r <= rec_all.stale;
    out_last_r  <= rec_all.last;
  end

  assign out_valid       = out_valid_r;
  assign out_sensor_id   = out_id_r;
  assign out_temperature = $signed(out_temp_r);
  assign out_humidity    = out_humid_r;
  assign out_stale       = out_stale_r;
  assign out_last        = out_last_r;

endmodule

>>> sv/ssa_cell.sv
// One slot of the aggregator chain: slot storage plus a token stage.
// Depends on ssa_pkg.
module ssa_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  ssa_pkg::cell_ctl_t ctl_i,
  input  logic              tok_i,
  input  logic              next_used_i,
  output logic              tok_o,
  output logic              hit_o,
  output logic              used_o,
  output logic              done_o,
  output ssa_pkg::cell_rec_t rec_o
);
  import ssa_pkg::*;

  logic              tok_r, used_r, upd_r;
  logic              used_nxt, upd_nxt;
  logic [ID_W-1:0]   id_r;
  logic [VAL_W-1:0]  temp_r, humid_r;
  logic [TIME_W-1:0] utime_r;
  logic [TIME_W-1:0] age;
  logic              hit, flush_here;

  // used slots form a prefix, so the first free cell comes after every match
  assign hit        = tok_r & ctl_i.scan & (~used_r | (id_r == ctl_i.id));
  assign flush_here = tok_r & ctl_i.flush;
  assign tok_o      = ctl_i.scan ? (tok_r & ~hit) : (flush_here & next_used_i);
  assign hit_o      = hit;
  assign used_o     = used_r;
  assign done_o     = ~used_r | upd_r;
  assign age        = ctl_i.time_now - utime_r;

  always_comb begin
    rec_o = '0;
    if (flush_here) begin
      rec_o.valid = 1'b1;
      rec_o.id    = id_r;
      rec_o.temp  = temp_r;
      rec_o.humid = humid_r;
      rec_o.stale = (age >= {{(TIME_W-CFG_W){1'b0}}, ctl_i.stale_thr});
      rec_o.last  = ~next_used_i;
    end
  end

  always_comb begin
    used_nxt = used_r;
    upd_nxt  = upd_r;
    if (hit) begin
      used_nxt = 1'b1;
      upd_nxt  = 1'b1;
    end else if (flush_here) begin
      upd_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r  <= 1'b0;
      used_r <= 1'b0;
      upd_r  <= 1'b0;
    end else begin
      tok_r  <= tok_i;
      used_r <= used_nxt;
      upd_r  <= upd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      id_r    <= ctl_i.id;
      temp_r  <= ctl_i.temp;
      humid_r <= ctl_i.humid;
      utime_r <= ctl_i.time_now;
    end
  end

endmodule

>>> sv/ssa_checker.sv
// Port-level checker for the sensor slot aggregator, bound to the top level.
// Depends on sensor_slot_aggregator_unit_assert.svh.
`include "sensor_slot_aggregator_unit_assert.svh"

module ssa_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_kind,
  input logic out_valid,
  input logic out_last
);

  // records of one flush leave back to back
  `SSA_ASSERT_NEXT(a_flush_cont, out_valid && !out_last, out_valid, "flush records not contiguous")
  // a record that is not the last leaves while the flush is still running
  `SSA_ASSERT_NOW(a_flush_busy, out_valid && !out_last, busy, "non-final record while idle")
  // the final record closes the burst
  `SSA_ASSERT_NEXT(a_last_ends, out_valid && out_last, !out_valid, "record after final one")
  // a reading always starts a slot search
  `SSA_ASSERT_NEXT(a_read_busy, start && !busy && !in_kind, busy, "reading not taken up")

endmodule

bind sensor_slot_aggregator_unit ssa_checker u_ssa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_kind   (in_kind),
  .out_valid (out_valid),
  .out_last  (out_last)
);
